// ----- hdl/rfd_pkg.sv -----
// Shared types and constants for the reply frame decoder.
package rfd_pkg;

    localparam logic [7:0] START_BYTE = 8'hF0;
    localparam int KEPT_PAYLOAD_BYTES = 8;
    localparam int KEPT_IDX_W = $clog2(KEPT_PAYLOAD_BYTES);
    localparam logic [7:0] LEN_PARAM_REPLY = 8'd8;
    localparam logic [7:0] LEN_PORT_REPLY = 8'd6;
    localparam logic [7:0] LEN_PROFILE_REPLY = 8'd8;
    localparam logic [15:0] PENDING_MAX = 16'hFFFF;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_TYPE_MODULE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TYPE_SYSTEM = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ID_PARAM = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ID_READY = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ID_PORT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ID_PROFILE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_EVENT_MASK = 3'd6;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_PARAM = 3'd1;
    localparam logic [2:0] EV_PORT = 3'd2;
    localparam logic [2:0] EV_PROFILE = 3'd3;
    localparam logic [2:0] EV_READY = 3'd4;
    localparam logic [2:0] EV_REJECT = 3'd5;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [15:0]        module_number;
        logic [15:0]        parameter_slot;
        logic signed [31:0] parameter_value;
        logic [15:0]        port_f_bits;
        logic [15:0]        port_g_bits;
        logic [15:0]        port_h_bits;
        logic [31:0]        profile_period;
        logic [31:0]        profile_cycles;
        logic [15:0]        pending_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0] type_module;
        logic [7:0] type_system;
        logic [7:0] id_param;
        logic [7:0] id_ready;
        logic [7:0] id_port;
        logic [7:0] id_profile;
        logic [2:0] event_mask;
    } cfg_t;

    typedef struct packed {
        logic                                done;
        logic [7:0]                          ftype;
        logic [7:0]                          fid;
        logic [7:0]                          flen;
        logic [KEPT_PAYLOAD_BYTES-1:0][7:0]  payload;
    } frame_t;

endpackage

// ----- hdl/rfd_cfg_regs.sv -----
// Configuration register bank for the reply frame decoder.
module rfd_cfg_regs
    import rfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TYPE_MODULE: cfg_next.type_module = cfg_wr_data;
                CFG_TYPE_SYSTEM: cfg_next.type_system = cfg_wr_data;
                CFG_ID_PARAM:    cfg_next.id_param = cfg_wr_data;
                CFG_ID_READY:    cfg_next.id_ready = cfg_wr_data;
                CFG_ID_PORT:     cfg_next.id_port = cfg_wr_data;
                CFG_ID_PROFILE:  cfg_next.id_profile = cfg_wr_data;
                CFG_EVENT_MASK:  cfg_next.event_mask = cfg_wr_data[2:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.type_module <= 8'd0;
            cfg_reg.type_system <= 8'd1;
            cfg_reg.id_param <= 8'd0;
            cfg_reg.id_ready <= 8'd0;
            cfg_reg.id_port <= 8'd1;
            cfg_reg.id_profile <= 8'd2;
            cfg_reg.event_mask <= 3'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/rfd_deframer.sv -----
// Byte deframer: header capture, payload store and frame completion.
module rfd_deframer
    import rfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output frame_t     frame
);

    typedef enum logic [2:0] {
        PH_START,
        PH_TYPE,
        PH_ID,
        PH_LEN,
        PH_PAYLOAD
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [8:0] cnt_sum;
    logic       done;
    logic       wr_en;
    logic [7:0] len_view;
    logic [KEPT_PAYLOAD_BYTES-1:0][7:0] store_reg;

    always_comb begin
        phase_next = phase_reg;
        type_next = type_reg;
        id_next = id_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        cnt_sum = {1'b0, cnt_reg} + 9'd1;
        done = 1'b0;
        wr_en = 1'b0;
        len_view = len_reg;
        if (step) begin
            case (phase_reg)
                PH_START: begin
                    if (rx_byte == START_BYTE) begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    type_next = rx_byte;
                    phase_next = PH_ID;
                end
                PH_ID: begin
                    id_next = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    len_next = rx_byte;
                    len_view = rx_byte;
                    cnt_next = 8'd0;
                    if (rx_byte == 8'd0) begin
                        done = 1'b1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    wr_en = (cnt_reg < 8'(KEPT_PAYLOAD_BYTES));
                    cnt_next = cnt_sum[7:0];
                    if (cnt_sum >= {1'b0, len_reg}) begin
                        done = 1'b1;
                    end
                end
                default: phase_next = PH_START;
            endcase
            if (done) begin
                cnt_next = 8'd0;
                phase_next = PH_START;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            type_reg <= 8'd0;
            id_reg <= 8'd0;
            len_reg <= 8'd0;
            cnt_reg <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            type_reg <= type_next;
            id_reg <= id_next;
            len_reg <= len_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[cnt_reg[KEPT_IDX_W-1:0]] <= rx_byte;
        end
    end

    // decode sees the byte being written this cycle
    always_comb begin
        frame.done = done;
        frame.ftype = type_reg;
        frame.fid = id_reg;
        frame.flen = len_view;
        for (int i = 0; i < KEPT_PAYLOAD_BYTES; i++) begin
            if (wr_en && (cnt_reg[KEPT_IDX_W-1:0] == KEPT_IDX_W'(i))) begin
                frame.payload[i] = rx_byte;
            end else begin
                frame.payload[i] = store_reg[i];
            end
        end
    end

endmodule

// ----- hdl/rfd_reply_decoder.sv -----
// Reply decode, field assembly and pending request counter.
module rfd_reply_decoder
    import rfd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  logic      kind,
    input  frame_t    frame,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [15:0] count_reg, count_next;
    logic        reply_ok;
    logic [7:0][7:0] p;

    assign p = frame.payload[7:0];

    always_comb begin
        result = '0;
        result.event_kind = EV_NONE;
        reply_ok = 1'b0;
        if (kind == KIND_BYTE && frame.done) begin
            if (frame.ftype == cfg.type_module) begin
                if (frame.fid == cfg.id_param && frame.flen >= LEN_PARAM_REPLY) begin
                    reply_ok = 1'b1;
                    if (cfg.event_mask[0]) begin
                        result.event_kind = EV_PARAM;
                        result.module_number = {p[1], p[0]};
                        result.parameter_slot = {p[3], p[2]};
                        result.parameter_value = {p[7], p[6], p[5], p[4]};
                    end
                end else begin
                    result.event_kind = EV_REJECT;
                end
            end else if (frame.ftype == cfg.type_system) begin
                if (frame.fid == cfg.id_ready) begin
                    reply_ok = 1'b1;
                    result.event_kind = EV_READY;
                end else if (frame.fid == cfg.id_port) begin
                    if (frame.flen < LEN_PORT_REPLY) begin
                        result.event_kind = EV_REJECT;
                    end else begin
                        reply_ok = 1'b1;
                        if (cfg.event_mask[1]) begin
                            result.event_kind = EV_PORT;
                            result.port_f_bits = {p[1], p[0]};
                            result.port_g_bits = {p[3], p[2]};
                            result.port_h_bits = {p[5], p[4]};
                        end
                    end
                end else if (frame.fid == cfg.id_profile) begin
                    if (frame.flen < LEN_PROFILE_REPLY) begin
                        result.event_kind = EV_REJECT;
                    end else begin
                        reply_ok = 1'b1;
                        if (cfg.event_mask[2]) begin
                            result.event_kind = EV_PROFILE;
                            result.profile_period = {p[3], p[2], p[1], p[0]};
                            result.profile_cycles = {p[7], p[6], p[5], p[4]};
                        end
                    end
                end else begin
                    result.event_kind = EV_REJECT;
                end
            end else begin
                result.event_kind = EV_REJECT;
            end
        end

        count_next = count_reg;
        if (step) begin
            if (kind == KIND_REQUEST) begin
                if (count_reg != PENDING_MAX) begin
                    count_next = count_reg + 16'd1;
                end
            end else if (reply_ok && count_reg != 16'd0) begin
                count_next = count_reg - 16'd1;
            end
        end
        result.pending_count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 16'd0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/dsp_reply_frame_decoder_unit.sv -----
// Top level of the reply frame decoder: request and result registers around the decode.
//
// Input channel s_valid/s_ready/s_data carries one request per cycle while s_ready is
// high: a received link byte (kind 0) or a note that a command went out expecting a
// reply (kind 1). Result channel m_valid/m_ready/m_data returns exactly one result per
// request: the event kind, the decoded little-endian reply fields (zero when not part
// of the event) and the outstanding reply count after that request.
// The request register feeds the decode and counter update, which load the result
// register when the request advances. Throughput is one request per cycle while
// the receiver accepts results; the parser state and the pending counter are
// updated in the single decode step, which sets that figure.
// When the receiver stalls the result register holds and the request register
// still takes one more request; s_ready falls only when both are full.
// Synchronous active-low reset empties both registers, returns the parser to
// waiting for a start byte, clears the counter and loads the register defaults.
// The cfg_wr_en/cfg_addr/cfg_wr_data port writes one register per cycle.
module dsp_reply_frame_decoder_unit
    import rfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;
    logic      byte_step;
    cfg_t      cfg;
    frame_t    frame;
    out_item_t result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign byte_step = advance && (in_data_reg.kind == KIND_BYTE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    rfd_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    rfd_deframer u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (byte_step),
        .rx_byte (in_data_reg.rx_byte),
        .frame   (frame)
    );

    rfd_reply_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .kind    (in_data_reg.kind),
        .frame   (frame),
        .cfg     (cfg),
        .result  (result)
    );

    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    a_param_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind != EV_PARAM |->
            m_data.module_number == 16'd0 && m_data.parameter_value == 32'sd0)
        else $error("param fields set outside a param value event");

    a_request_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.kind == KIND_REQUEST |=> m_data.pending_count != 16'd0)
        else $error("request left pending count at zero");

    a_request_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.kind == KIND_REQUEST |=> m_data.event_kind == EV_NONE)
        else $error("request produced an event");

endmodule

// ----- test/reply_decode_checker.sv -----
`timescale 1ns / 100ps
// Watches the decoder's request, result and register ports, predicts every result and compares.
module reply_decode_checker
    import rfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    mismatches,
    output int                    results_due,
    output int                    results_checked,
    output int                    replies_decoded,
    output int                    frames_rejected
);

    typedef enum logic [2:0] {
        HUNT_START,
        TAKE_TYPE,
        TAKE_ID,
        TAKE_LEN,
        TAKE_PAYLOAD
    } parse_phase_e;

    localparam cfg_t REG_DEFAULTS = '{
        type_module: 8'h00,
        type_system: 8'h01,
        id_param:    8'h00,
        id_ready:    8'h00,
        id_port:     8'h01,
        id_profile:  8'h02,
        event_mask:  3'b000
    };

    cfg_t         regs;
    parse_phase_e phase;
    logic [7:0]   frame_type;
    logic [7:0]   frame_id;
    logic [7:0]   frame_len;
    logic [7:0]   byte_cnt;
    logic [7:0]   kept [KEPT_PAYLOAD_BYTES];
    logic [15:0]  awaiting;
    out_item_t    due_results [$];

    function automatic void settle_reply();
        if (awaiting != 16'd0) begin
            awaiting = awaiting - 16'd1;
        end
    endfunction

    function automatic out_item_t decode_request(in_item_t req);
        out_item_t res;
        logic      done;
        res  = '0;
        done = 1'b0;
        if (req.kind == KIND_REQUEST) begin
            if (awaiting != PENDING_MAX) begin
                awaiting = awaiting + 16'd1;
            end
        end else begin
            case (phase)
                HUNT_START: begin
                    if (req.rx_byte == START_BYTE) begin
                        phase = TAKE_TYPE;
                    end
                end
                TAKE_TYPE: begin
                    frame_type = req.rx_byte;
                    phase = TAKE_ID;
                end
                TAKE_ID: begin
                    frame_id = req.rx_byte;
                    phase = TAKE_LEN;
                end
                TAKE_LEN: begin
                    frame_len = req.rx_byte;
                    byte_cnt = '0;
                    if (req.rx_byte == 8'd0) begin
                        done = 1'b1;
                    end else begin
                        phase = TAKE_PAYLOAD;
                    end
                end
                TAKE_PAYLOAD: begin
                    // bytes past the kept window only advance the count
                    if (byte_cnt < KEPT_PAYLOAD_BYTES) begin
                        kept[byte_cnt[KEPT_IDX_W-1:0]] = req.rx_byte;
                    end
                    byte_cnt = byte_cnt + 8'd1;
                    done = (byte_cnt >= frame_len);
                end
                default: begin
                    phase = HUNT_START;
                end
            endcase
        end
        if (done) begin
            byte_cnt = '0;
            phase = HUNT_START;
            res.event_kind = EV_REJECT;
            // module type wins over system type when the codes collide
            if (frame_type == regs.type_module) begin
                if (frame_id == regs.id_param && frame_len >= LEN_PARAM_REPLY) begin
                    settle_reply();
                    res.event_kind = EV_NONE;
                    if (regs.event_mask[0]) begin
                        res.event_kind      = EV_PARAM;
                        res.module_number   = {kept[1], kept[0]};
                        res.parameter_slot  = {kept[3], kept[2]};
                        res.parameter_value = {kept[7], kept[6], kept[5], kept[4]};
                    end
                end
            end else if (frame_type == regs.type_system) begin
                if (frame_id == regs.id_ready) begin
                    settle_reply();
                    res.event_kind = EV_READY;
                end else if (frame_id == regs.id_port) begin
                    if (frame_len >= LEN_PORT_REPLY) begin
                        settle_reply();
                        res.event_kind = EV_NONE;
                        if (regs.event_mask[1]) begin
                            res.event_kind  = EV_PORT;
                            res.port_f_bits = {kept[1], kept[0]};
                            res.port_g_bits = {kept[3], kept[2]};
                            res.port_h_bits = {kept[5], kept[4]};
                        end
                    end
                end else if (frame_id == regs.id_profile) begin
                    if (frame_len >= LEN_PROFILE_REPLY) begin
                        settle_reply();
                        res.event_kind = EV_NONE;
                        if (regs.event_mask[2]) begin
                            res.event_kind     = EV_PROFILE;
                            res.profile_period = {kept[3], kept[2], kept[1], kept[0]};
                            res.profile_cycles = {kept[7], kept[6], kept[5], kept[4]};
                        end
                    end
                end
            end
        end
        res.pending_count = awaiting;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            regs = REG_DEFAULTS;
            phase = HUNT_START;
            frame_type = '0;
            frame_id = '0;
            frame_len = '0;
            byte_cnt = '0;
            awaiting = '0;
            foreach (kept[i]) kept[i] = '0;
            due_results.delete();
            mismatches = 0;
            results_checked = 0;
            replies_decoded = 0;
            frames_rejected = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_TYPE_MODULE: regs.type_module = cfg_wr_data;
                    CFG_TYPE_SYSTEM: regs.type_system = cfg_wr_data;
                    CFG_ID_PARAM:    regs.id_param = cfg_wr_data;
                    CFG_ID_READY:    regs.id_ready = cfg_wr_data;
                    CFG_ID_PORT:     regs.id_port = cfg_wr_data;
                    CFG_ID_PROFILE:  regs.id_profile = cfg_wr_data;
                    CFG_EVENT_MASK:  regs.event_mask = cfg_wr_data[2:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                due_results.push_back(decode_request(s_data));
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no request awaiting it: event_kind %0d",
                           m_data.event_kind);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("event_kind", 32'(want.event_kind), 32'(m_data.event_kind));
                    check_field("module_number", 32'(want.module_number),
                                32'(m_data.module_number));
                    check_field("parameter_slot", 32'(want.parameter_slot),
                                32'(m_data.parameter_slot));
                    check_field("parameter_value", want.parameter_value,
                                m_data.parameter_value);
                    check_field("port_f_bits", 32'(want.port_f_bits), 32'(m_data.port_f_bits));
                    check_field("port_g_bits", 32'(want.port_g_bits), 32'(m_data.port_g_bits));
                    check_field("port_h_bits", 32'(want.port_h_bits), 32'(m_data.port_h_bits));
                    check_field("profile_period", want.profile_period, m_data.profile_period);
                    check_field("profile_cycles", want.profile_cycles, m_data.profile_cycles);
                    check_field("pending_count", 32'(want.pending_count),
                                32'(m_data.pending_count));
                    results_checked++;
                    if (want.event_kind == EV_REJECT) begin
                        frames_rejected++;
                    end else if (want.event_kind != EV_NONE) begin
                        replies_decoded++;
                    end
                end
            end
        end
        results_due <= due_results.size();
    end

endmodule

// ----- test/dsp_reply_frame_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: feeds link bytes, reply requests and register writes, gives the verdict.
module dsp_reply_frame_decoder_unit_tb;
    import rfd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int REQUEST_BURST = 20;
    localparam int PHASE_ITEMS = 70;

    localparam cfg_t SET_DIRECTED = '{
        type_module: 8'h00, type_system: 8'h01, id_param: 8'h00, id_ready: 8'h00,
        id_port: 8'h01, id_profile: 8'h02, event_mask: 3'b111
    };
    // both types and all system ids collide, param, port and profile events masked
    localparam cfg_t SET_COLLIDE = '{
        type_module: 8'hFF, type_system: 8'hFF, id_param: 8'hFF, id_ready: 8'h10,
        id_port: 8'h10, id_profile: 8'h10, event_mask: 3'b000
    };
    localparam cfg_t SET_PORT_FIRST = '{
        type_module: 8'h5A, type_system: 8'hA5, id_param: 8'h33, id_ready: 8'hC3,
        id_port: 8'h3C, id_profile: 8'h3C, event_mask: 3'b101
    };
    localparam cfg_t SET_EXTREME = '{
        type_module: 8'h80, type_system: 8'h7F, id_param: 8'h00, id_ready: 8'hFF,
        id_port: 8'h55, id_profile: 8'hAA, event_mask: 3'b010
    };
    localparam cfg_t SET_DEFAULT = '{
        type_module: 8'h00, type_system: 8'h01, id_param: 8'h00, id_ready: 8'h00,
        id_port: 8'h01, id_profile: 8'h02, event_mask: 3'b111
    };

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int   mismatches;
    int   results_due;
    int   results_checked;
    int   replies_decoded;
    int   frames_rejected;

    cfg_t cur;
    int   sent_items = 0;
    int   requests_sent = 0;
    int   settings_applied = 0;
    int   holds_asked = 0;
    logic quiet = 1'b0;

    dsp_reply_frame_decoder_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    reply_decode_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .mismatches      (mismatches),
        .results_due     (results_due),
        .results_checked (results_checked),
        .replies_decoded (replies_decoded),
        .frames_rejected (frames_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : receiver
        int holds_taken;
        int r;
        holds_taken = 0;
        forever begin
            if (holds_taken < holds_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                holds_taken++;
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                m_ready <= (r < 65);
                if (r < 65) begin
                    repeat ($urandom_range(1, 16)) @(posedge aclk);
                end else if (r < 95) begin
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    repeat ($urandom_range(8, 40)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("dsp_reply_frame_decoder_unit verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] any_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'h00;
        end
        if (r == 1) begin
            return 8'hFF;
        end
        if (r == 2) begin
            return 8'h80;
        end
        return 8'($urandom);
    endfunction

    function automatic logic [63:0] random_payload();
        logic [63:0] fill;
        for (int i = 0; i < 8; i++) begin
            fill[8*i +: 8] = any_byte();
        end
        return fill;
    endfunction

    task automatic send(input logic k, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= {k, b};
        do @(posedge aclk); while (!s_ready);
        sent_items++;
        if (k == KIND_REQUEST) begin
            requests_sent++;
        end
    endtask

    // payload byte i comes from fill while i is in the kept window; a request
    // is slipped in before payload byte req_at
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fid,
                              input logic [7:0] flen, input logic [63:0] fill,
                              input int req_at);
        int i;
        send(KIND_BYTE, START_BYTE);
        send(KIND_BYTE, ftype);
        send(KIND_BYTE, fid);
        send(KIND_BYTE, flen);
        for (i = 0; i < flen; i++) begin
            if (i == req_at) begin
                send(KIND_REQUEST, any_byte());
            end
            if (i < KEPT_PAYLOAD_BYTES) begin
                send(KIND_BYTE, fill[8*i +: 8]);
            end else begin
                send(KIND_BYTE, any_byte());
            end
        end
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wr_data <= d;
        @(posedge aclk);
    endtask

    task automatic load_regs(input cfg_t c);
        put_reg(CFG_TYPE_MODULE, c.type_module);
        put_reg(CFG_TYPE_SYSTEM, c.type_system);
        put_reg(CFG_ID_PARAM, c.id_param);
        put_reg(CFG_ID_READY, c.id_ready);
        put_reg(CFG_ID_PORT, c.id_port);
        put_reg(CFG_ID_PROFILE, c.id_profile);
        put_reg(CFG_EVENT_MASK, CFG_DATA_W'(c.event_mask));
        cfg_wr_en <= 1'b0;
        cur = c;
        settings_applied++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_traffic();
        int         r;
        int         req_at;
        logic [2:0] aim;
        logic [7:0] ftype;
        logic [7:0] fid;
        logic [7:0] flen;
        logic [7:0] need;
        repeat ($urandom_range(0, 2)) send(KIND_REQUEST, any_byte());
        req_at = -1;
        if ($urandom_range(0, 9) == 0) begin
            req_at = $urandom_range(0, 12);
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            aim = 3'($urandom_range(EV_PARAM, EV_READY));
            ftype = cur.type_system;
            case (aim)
                EV_PARAM: begin
                    ftype = cur.type_module;
                    fid = cur.id_param;
                    need = LEN_PARAM_REPLY;
                end
                EV_PORT: begin
                    fid = cur.id_port;
                    need = LEN_PORT_REPLY;
                end
                EV_PROFILE: begin
                    fid = cur.id_profile;
                    need = LEN_PROFILE_REPLY;
                end
                default: begin
                    fid = cur.id_ready;
                    need = 8'd0;
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < 75) begin
                flen = need + 8'($urandom_range(0, 4));
            end else if (r < 88) begin
                flen = 8'($urandom_range(0, need));
            end else if (r < 97) begin
                flen = 8'($urandom_range(need + 5, 40));
            end else begin
                flen = 8'($urandom_range(200, 255));
            end
            send_frame(ftype, fid, flen, random_payload(), req_at);
        end else if (r < 88) begin
            send_frame(any_byte(), any_byte(), 8'($urandom_range(0, 20)), random_payload(),
                       req_at);
        end else begin
            repeat ($urandom_range(1, 6)) send(KIND_BYTE, any_byte());
        end
    endtask

    task automatic run_random();
        int stop;
        stop = sent_items + PHASE_ITEMS;
        while (sent_items < stop) begin
            random_traffic();
        end
    endtask

    initial begin : stimulus
        cfg_t        roll;
        logic [63:0] raw;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_regs(SET_DIRECTED);
        send(KIND_BYTE, 8'h00);
        send(KIND_BYTE, 8'hFF);
        // zero-length ready reply with nothing outstanding, reply requests straight after
        send_frame(cur.type_system, cur.id_ready, 8'd0, '0, -1);
        send(KIND_REQUEST, 8'h00);
        send(KIND_REQUEST, 8'hFF);
        send(KIND_REQUEST, 8'h5A);
        send_frame(cur.type_module, cur.id_param, 8'd8, 64'hFFFF_FFFF_8000_FFFF, -1);
        send_frame(cur.type_module, cur.id_param, 8'd8, 64'h8000_0000_0000_0000, 3);
        send_frame(cur.type_system, cur.id_port, 8'd6, 64'h0000_FFFF_8000_0001, -1);
        send_frame(cur.type_system, cur.id_profile, 8'd8, 64'h8000_0001_FFFF_FFFF, -1);
        send_frame(cur.type_module, cur.id_param, 8'd7, 64'h0102_0304_0506_0708, -1);
        send_frame(cur.type_system, cur.id_port, 8'd5, 64'h0102_0304_0506_0708, -1);
        send_frame(cur.type_system, cur.id_profile, 8'd7, 64'h0102_0304_0506_0708, -1);
        send_frame(8'h77, 8'h00, 8'd2, 64'hFFFF, -1);
        send_frame(cur.type_system, 8'h99, 8'd1, 64'h00, -1);
        send_frame(cur.type_module, cur.id_param, 8'd12, 64'h7FFF_FFFF_1234_ABCD, -1);
        send_frame(cur.type_module, cur.id_param, 8'd8, 64'h0000_0000_0000_0000, -1);
        drain();

        load_regs(SET_COLLIDE);
        run_random();
        drain();

        load_regs(SET_PORT_FIRST);
        holds_asked = 1;
        run_random();
        drain();

        load_regs(SET_EXTREME);
        quiet = 1'b1;
        run_random();
        quiet = 1'b0;
        drain();

        raw = {$urandom, $urandom};
        roll = raw[$bits(cfg_t)-1:0];
        load_regs(roll);
        run_random();
        drain();

        // a burst of reply requests, then let replies bring the count down
        load_regs(SET_DEFAULT);
        quiet = 1'b1;
        repeat (REQUEST_BURST) send(KIND_REQUEST, any_byte());
        quiet = 1'b0;
        run_random();
        drain();

        $display("Covered %0d requests, %0d of them reply requests, over %0d register settings",
                 sent_items, requests_sent, settings_applied);
        $display("Checked %0d results: %0d replies decoded, %0d frames rejected",
                 results_checked, replies_decoded, frames_rejected);
        if (mismatches == 0) begin
            $display("dsp_reply_frame_decoder_unit verification clean");
        end else begin
            $display("dsp_reply_frame_decoder_unit verification failed");
        end
        $finish;
    end

endmodule
